/* sv/ctk_pkg.sv */
// Shared types, codes and constants of the command line tokenizer.
package ctk_pkg;

    localparam int MAX_TOKENS    = 16;
    localparam int MAX_TOKEN_LEN = 256;
    localparam int MAX_RESULTS   = 6;
    localparam int STEP_ITERS    = 5;

    localparam int ARG_W    = $clog2(MAX_TOKENS + 1);
    localparam int CHAR_W   = $clog2(MAX_TOKEN_LEN);
    localparam int N_W      = $clog2(MAX_RESULTS + 1);
    localparam int EV_IDX_W = $clog2(MAX_RESULTS);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_TOKEN  = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_QOPEN  = 3'd3;
    localparam logic [2:0] MODE_LINE   = 3'd4;
    localparam logic [2:0] MODE_BLOCK  = 3'd5;

    localparam logic [2:0] EV_BYTE       = 3'd0;
    localparam logic [2:0] EV_TOKEN_END  = 3'd1;
    localparam logic [2:0] EV_CMD_END    = 3'd2;
    localparam logic [2:0] EV_NO_QUOTE   = 3'd3;
    localparam logic [2:0] EV_NO_COMMENT = 3'd4;
    localparam logic [2:0] EV_TOO_MANY   = 3'd5;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [2:0]        mode;
        logic              slash;
        logic              star;
        logic [ARG_W-1:0]  argc;
        logic [CHAR_W-1:0] charc;
    } t_state;

    localparam t_state STATE_RESET = t_state'('0);

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] token_byte;
        logic [3:0] arg_index;
        logic [7:0] char_index;
    } t_event;

    typedef struct packed {
        t_state                        st;
        t_event [MAX_RESULTS-1:0]      ev;
        logic   [N_W-1:0]              n;
    } t_work;

endpackage

/* sv/ctk_if.sv */
// Stream interfaces for text bytes in and tokenizer events out.
interface ctk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctk_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] token_byte;
    logic [3:0] arg_index;
    logic [7:0] char_index;
    logic       last_of_run;

    modport source (output valid, output event_kind, output token_byte, output arg_index,
                    output char_index, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input token_byte, input arg_index,
                    input char_index, input last_of_run, output ready);
endinterface

/* sv/ctk_step.sv */
// Per-byte tokenizer step: next state and the list of events one byte causes.
module ctk_step (
    input  ctk_pkg::t_state i_state,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_text,
    output ctk_pkg::t_work  o_work
);

    function automatic ctk_pkg::t_work f_emit(ctk_pkg::t_work w, logic [2:0] kind,
                                              logic [7:0] tb, logic [3:0] ai,
                                              logic [7:0] ci);
        if (w.n < ctk_pkg::N_W'(ctk_pkg::MAX_RESULTS)) begin
            w.ev[w.n[ctk_pkg::EV_IDX_W-1:0]] = ctk_pkg::t_event'{
                event_kind: kind, token_byte: tb, arg_index: ai, char_index: ci};
            w.n = w.n + ctk_pkg::N_W'(1);
        end
        return w;
    endfunction

    function automatic logic f_full(ctk_pkg::t_work w);
        return w.st.argc >= ctk_pkg::ARG_W'(ctk_pkg::MAX_TOKENS);
    endfunction

    function automatic logic f_cut(ctk_pkg::t_work w);
        return w.st.charc >= ctk_pkg::CHAR_W'(ctk_pkg::MAX_TOKEN_LEN - 1);
    endfunction

    function automatic ctk_pkg::t_work f_emit_char(ctk_pkg::t_work w, logic [7:0] b);
        w = f_emit(w, ctk_pkg::EV_BYTE, b, 4'(w.st.argc), 8'(w.st.charc));
        w.st.charc = w.st.charc + ctk_pkg::CHAR_W'(1);
        return w;
    endfunction

    function automatic ctk_pkg::t_work f_token_end(ctk_pkg::t_work w);
        w = f_emit(w, ctk_pkg::EV_TOKEN_END, 8'd0, 4'(w.st.argc), 8'(w.st.charc));
        if (!f_full(w)) begin
            w.st.argc = w.st.argc + ctk_pkg::ARG_W'(1);
        end
        w.st.charc = '0;
        w.st.mode  = ctk_pkg::MODE_NORMAL;
        return w;
    endfunction

    function automatic ctk_pkg::t_work f_start(ctk_pkg::t_work w, logic [7:0] b);
        w.st.mode  = ctk_pkg::MODE_TOKEN;
        w.st.charc = '0;
        return f_emit_char(w, b);
    endfunction

    // held slash turned out to be an ordinary byte
    function automatic ctk_pkg::t_work f_slash_flush(ctk_pkg::t_work w);
        if (w.st.mode == ctk_pkg::MODE_TOKEN) begin
            w = f_emit_char(w, ctk_pkg::CH_SLASH);
        end else if (f_full(w)) begin
            w = f_emit(w, ctk_pkg::EV_TOO_MANY, 8'd0, 4'd0, 8'd0);
        end else begin
            w = f_start(w, ctk_pkg::CH_SLASH);
        end
        return w;
    endfunction

    ctk_pkg::t_work w;
    logic           done;
    logic [7:0]     b;
    logic           b_ctrl;

    assign b      = i_text_byte;
    assign b_ctrl = (b >= 8'd1) && (b < 8'd32);

    always_comb begin
        w    = '0;
        w.st = i_state;
        done = 1'b0;
        for (int it = 0; it < ctk_pkg::STEP_ITERS; it++) begin
            if (!done) begin
                if (w.st.slash) begin
                    w.st.slash = 1'b0;
                    if (b == ctk_pkg::CH_SLASH || b == ctk_pkg::CH_STAR) begin
                        if (w.st.mode == ctk_pkg::MODE_TOKEN) begin
                            w = f_token_end(w);
                        end
                        w.st.mode = (b == ctk_pkg::CH_SLASH) ? ctk_pkg::MODE_LINE
                                                            : ctk_pkg::MODE_BLOCK;
                        w.st.star = 1'b0;
                        done      = 1'b1;
                    end else begin
                        w = f_slash_flush(w);
                    end
                end else begin
                    unique case (w.st.mode)
                        ctk_pkg::MODE_NORMAL: begin
                            done = 1'b1;
                            if (b == ctk_pkg::CH_SLASH) begin
                                w.st.slash = 1'b1;
                            end else if (b == ctk_pkg::CH_NL || b == ctk_pkg::CH_SEMI) begin
                                if (w.st.argc != '0) begin
                                    w = f_emit(w, ctk_pkg::EV_CMD_END, 8'd0,
                                               4'(w.st.argc - ctk_pkg::ARG_W'(1)), 8'd0);
                                end
                                w.st.argc = '0;
                            end else if (b_ctrl || b == ctk_pkg::CH_SPACE) begin
                                w.st.star = w.st.star;
                            end else if (f_full(w)) begin
                                w = f_emit(w, ctk_pkg::EV_TOO_MANY, 8'd0, 4'd0, 8'd0);
                            end else if (b == ctk_pkg::CH_QUOTE) begin
                                w.st.mode = ctk_pkg::MODE_QOPEN;
                            end else begin
                                w = f_start(w, b);
                            end
                        end
                        ctk_pkg::MODE_TOKEN: begin
                            if (f_cut(w) || b_ctrl || b == ctk_pkg::CH_QUOTE ||
                                b == ctk_pkg::CH_SPACE || b == ctk_pkg::CH_SEMI) begin
                                w = f_token_end(w);
                            end else begin
                                done = 1'b1;
                                if (b == ctk_pkg::CH_SLASH) begin
                                    w.st.slash = 1'b1;
                                end else begin
                                    w = f_emit_char(w, b);
                                end
                            end
                        end
                        ctk_pkg::MODE_QUOTED: begin
                            if (b == ctk_pkg::CH_QUOTE) begin
                                w    = f_token_end(w);
                                done = 1'b1;
                            end else if (f_cut(w) || b_ctrl) begin
                                w = f_emit(w, ctk_pkg::EV_NO_QUOTE, 8'd0,
                                           4'(w.st.argc), 8'd0);
                                w = f_token_end(w);
                            end else begin
                                w    = f_emit_char(w, b);
                                done = 1'b1;
                            end
                        end
                        ctk_pkg::MODE_QOPEN: begin
                            if (b == ctk_pkg::CH_QUOTE) begin
                                w.st.mode = ctk_pkg::MODE_NORMAL;
                                done      = 1'b1;
                            end else begin
                                w.st.mode  = ctk_pkg::MODE_QUOTED;
                                w.st.charc = '0;
                            end
                        end
                        ctk_pkg::MODE_LINE: begin
                            if (b == ctk_pkg::CH_NL) begin
                                w.st.mode = ctk_pkg::MODE_NORMAL;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                            if (w.st.star && b == ctk_pkg::CH_SLASH) begin
                                w.st.mode = ctk_pkg::MODE_NORMAL;
                                w.st.star = 1'b0;
                            end else begin
                                w.st.star = (b == ctk_pkg::CH_STAR);
                            end
                        end
                    endcase
                end
            end
        end

        if (i_end_of_text) begin
            if (w.st.slash) begin
                w.st.slash = 1'b0;
                w = f_slash_flush(w);
            end
            unique case (w.st.mode)
                ctk_pkg::MODE_TOKEN: begin
                    w = f_token_end(w);
                end
                ctk_pkg::MODE_QUOTED: begin
                    w = f_emit(w, ctk_pkg::EV_NO_QUOTE, 8'd0, 4'(w.st.argc), 8'd0);
                    w = f_token_end(w);
                end
                ctk_pkg::MODE_QOPEN: begin
                    w = f_emit(w, ctk_pkg::EV_NO_QUOTE, 8'd0, 4'(w.st.argc), 8'd0);
                end
                ctk_pkg::MODE_BLOCK: begin
                    w = f_emit(w, ctk_pkg::EV_NO_COMMENT, 8'd0, 4'd0, 8'd0);
                end
                default: begin
                    w.st.star = w.st.star;
                end
            endcase
            if (w.st.argc != '0) begin
                w = f_emit(w, ctk_pkg::EV_CMD_END, 8'd0,
                           4'(w.st.argc - ctk_pkg::ARG_W'(1)), 8'd0);
            end
            w.st = ctk_pkg::STATE_RESET;
        end
    end

    assign o_work = w;

endmodule

/* sv/command_line_tokenizer_core.sv */
// Top level of the command line tokenizer: input register, step logic, event buffer.
//
//  channel   dir  payload                                              transaction
//  i_text    in   text_byte[8], end_of_text[1]                          valid & ready
//  o_event   out  event_kind[3], token_byte[8], arg_index[4],
//                 char_index[8], last_of_run[1]                          valid & ready
//
// A byte is registered on input, decoded combinationally into up to six events held in
// the event buffer, and the buffer drains one event per cycle on o_event while it is
// ready. Sustained rate: one byte per cycle while o_event is ready and each byte
// yields at most one event; a byte of k events holds the buffer until all k drain.
// Synchronous active-low reset returns the parser to between-tokens and empties both
// stages. A stalled o_event holds its event; one byte still enters the input register.
module command_line_tokenizer_core (
    input logic       i_clk,
    input logic       i_rst_n,
    ctk_in_if.sink    i_text,
    ctk_out_if.source o_event
);

    logic                                 r_in_valid;
    logic [7:0]                           r_in_byte;
    logic                                 r_in_eot;
    ctk_pkg::t_state                      r_state;
    ctk_pkg::t_event [ctk_pkg::MAX_RESULTS-1:0] r_ev;
    logic [ctk_pkg::N_W-1:0]              r_cnt;
    logic [ctk_pkg::N_W-1:0]              r_rd;
    logic [ctk_pkg::N_W-1:0]              n_rd;

    ctk_pkg::t_work  work;
    ctk_pkg::t_event cur;
    logic            out_valid;
    logic            out_last;
    logic            out_take;
    logic            batch_free;
    logic            move;
    logic            in_take;

    ctk_step u_step (
        .i_state       (r_state),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .o_work        (work)
    );

    assign out_valid  = (r_rd != r_cnt);
    assign out_last   = (r_rd == r_cnt - ctk_pkg::N_W'(1));
    assign out_take   = out_valid && o_event.ready;
    assign batch_free = !out_valid || (out_take && out_last);
    assign move       = r_in_valid && batch_free;
    assign in_take    = i_text.valid && i_text.ready;
    assign n_rd       = r_rd + ctk_pkg::N_W'(1);

    assign i_text.ready = !r_in_valid || batch_free;

    assign cur                 = r_ev[r_rd[ctk_pkg::EV_IDX_W-1:0]];
    assign o_event.valid       = out_valid;
    assign o_event.event_kind  = cur.event_kind;
    assign o_event.token_byte  = cur.token_byte;
    assign o_event.arg_index   = cur.arg_index;
    assign o_event.char_index  = cur.char_index;
    assign o_event.last_of_run = out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ctk_pkg::STATE_RESET;
            r_cnt      <= '0;
            r_rd       <= '0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !move);
            if (move) begin
                r_state <= work.st;
                r_cnt   <= work.n;
                r_rd    <= '0;
            end else if (out_take) begin
                r_rd <= n_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text.text_byte;
            r_in_eot  <= i_text.end_of_text;
        end
        if (move) begin
            r_ev <= work.ev;
        end
    end

endmodule

/* sv/ctk_checker.sv */
// Port-level assertions for the tokenizer top level, with the bind that attaches them.
module ctk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_event_kind,
    input logic [7:0] i_token_byte,
    input logic [3:0] i_arg_index,
    input logic [7:0] i_char_index,
    input logic       i_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event output valid right after reset");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_of_run |=> i_out_valid)
        else $error("event run ended before its last event");

    a_byte_only_kind0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind != ctk_pkg::EV_BYTE |->
            i_token_byte == 8'd0)
        else $error("token byte set on a non-byte event");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_kind) && $stable(i_token_byte) &&
            $stable(i_arg_index) && $stable(i_char_index) && $stable(i_last_of_run))
        else $error("stalled event transaction changed");

endmodule

bind command_line_tokenizer_core ctk_checker u_ctk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_event.valid),
    .i_out_ready   (o_event.ready),
    .i_event_kind  (o_event.event_kind),
    .i_token_byte  (o_event.token_byte),
    .i_arg_index   (o_event.arg_index),
    .i_char_index  (o_event.char_index),
    .i_last_of_run (o_event.last_of_run)
);
